>>> sv/mcm_pkg.sv
// Shared types and constants for the matrix chain minimum cost block.
package mcm_pkg;

    localparam int DIM_W  = 16;
    localparam int COST_W = 53;
    localparam int STAT_W = 2;

    localparam logic [COST_W-1:0] COST_MAX = '1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_SHORT = 2'd1;
    localparam logic [STAT_W-1:0] ST_LONG  = 2'd2;

    typedef struct packed {
        logic [DIM_W-1:0] dim;
        logic             last;
    } t_in_beat;

    typedef struct packed {
        logic [COST_W-1:0] min_cost;
        logic [STAT_W-1:0] status;
    } t_out_beat;

    typedef struct packed {
        logic              dim_wr;
        logic              rd;
        logic              first;
        logic              last_split;
        logic              mul1;
        logic              mul2;
        logic              acc;
        logic              cost_wr;
        logic              out_load;
        logic              out_use_best;
        logic [STAT_W-1:0] out_status;
    } t_dp_cmd;

endpackage

>>> sv/mcm_dpath.sv
// Datapath: dimension store, cost table, split cost arithmetic and result register.
module mcm_dpath #(
    parameter int MAX_MATRICES = 32,
    parameter int DIM_BITS     = 16
) (
    input  logic                                i_clk,
    input  mcm_pkg::t_dp_cmd                    i_cmd,
    input  logic [mcm_pkg::DIM_W-1:0]           i_in_dim,
    input  logic [$clog2(MAX_MATRICES+1)-1:0]   i_i,
    input  logic [$clog2(MAX_MATRICES+1)-1:0]   i_k,
    input  logic [$clog2(MAX_MATRICES+1)-1:0]   i_j,
    input  logic [$clog2(MAX_MATRICES+1)-1:0]   i_dim_wa,
    input  logic [$clog2(MAX_MATRICES+1)-1:0]   i_dim_ra,
    input  logic [$clog2(MAX_MATRICES+1)-1:0]   i_dim_rb,
    output mcm_pkg::t_out_beat                  o_out_beat
);

    localparam int DEPTH_D = MAX_MATRICES + 1;
    localparam int DEPTH_C = MAX_MATRICES * MAX_MATRICES;
    localparam int AW      = (DEPTH_C > 1) ? $clog2(DEPTH_C) : 1;
    localparam int PW      = 3 * DIM_BITS;
    localparam int CW      = mcm_pkg::COST_W;
    localparam int SW      = mcm_pkg::COST_W + 2;

    logic [DIM_BITS-1:0]   r_dim_mem [DEPTH_D];
    logic [CW-1:0]         r_cost_mem [DEPTH_C];

    logic [DIM_BITS-1:0]   r_dra;
    logic [DIM_BITS-1:0]   r_drb;
    logic [DIM_BITS-1:0]   r_di;
    logic [DIM_BITS-1:0]   r_dj1;
    logic [CW-1:0]         r_ca;
    logic [CW-1:0]         r_cb;
    logic                  r_za;
    logic                  r_zb;
    logic [2*DIM_BITS-1:0] r_ab;
    logic [CW:0]           r_csum;
    logic [CW-1:0]         r_tri;
    logic [CW-1:0]         r_best;
    mcm_pkg::t_out_beat    r_out;

    logic [AW-1:0]         w_addr_ik;
    logic [AW-1:0]         w_addr_kj;
    logic [AW-1:0]         w_addr_ij;
    logic [PW-1:0]         w_prod;
    logic [SW-1:0]         w_qsum;
    logic [CW-1:0]         w_q;

    // row-major table, stride MAX_MATRICES
    assign w_addr_ik = AW'(int'(i_i) * MAX_MATRICES + int'(i_k));
    assign w_addr_kj = AW'((int'(i_k) + 1) * MAX_MATRICES + int'(i_j));
    assign w_addr_ij = AW'(int'(i_i) * MAX_MATRICES + int'(i_j));

    assign w_prod = PW'(r_ab) * PW'(r_dj1);
    assign w_qsum = SW'(r_csum) + SW'(r_tri);
    assign w_q    = (w_qsum > SW'(mcm_pkg::COST_MAX)) ? mcm_pkg::COST_MAX : CW'(w_qsum);

    always_ff @(posedge i_clk) begin
        if (i_cmd.dim_wr) begin
            r_dim_mem[i_dim_wa] <= DIM_BITS'(i_in_dim);
        end
        r_dra <= r_dim_mem[i_dim_ra];
        r_drb <= r_dim_mem[i_dim_rb];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cost_wr) begin
            r_cost_mem[w_addr_ij] <= r_best;
        end
        if (i_cmd.rd) begin
            r_ca <= r_cost_mem[w_addr_ik];
            r_cb <= r_cost_mem[w_addr_kj];
            r_za <= i_cmd.first;
            r_zb <= i_cmd.last_split;
        end
    end

    always_ff @(posedge i_clk) begin
        // interval end dimensions were read during the setup cycle
        if (i_cmd.rd && i_cmd.first) begin
            r_di  <= r_dra;
            r_dj1 <= r_drb;
        end
        if (i_cmd.mul1) begin
            r_ab   <= (2*DIM_BITS)'(r_di) * (2*DIM_BITS)'(r_dra);
            // diagonal entries are zero and never stored
            r_csum <= (r_za ? '0 : (CW+1)'(r_ca)) + (r_zb ? '0 : (CW+1)'(r_cb));
        end
        if (i_cmd.mul2) begin
            r_tri <= ((w_prod >> CW) != '0) ? mcm_pkg::COST_MAX : CW'(w_prod);
        end
        if (i_cmd.acc) begin
            if (i_cmd.first || (w_q < r_best)) begin
                r_best <= w_q;
            end
        end
        if (i_cmd.out_load) begin
            r_out.min_cost <= i_cmd.out_use_best ? r_best : '0;
            r_out.status   <= i_cmd.out_status;
        end
    end

    assign o_out_beat = r_out;

endmodule

>>> sv/mcm_ctrl.sv
// Controller: dimension loading, interval/split sequencing and result handshake.
module mcm_ctrl #(
    parameter int MAX_MATRICES = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_last,
    input  logic                                i_out_stall,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output mcm_pkg::t_dp_cmd                    o_cmd,
    output logic [$clog2(MAX_MATRICES+1)-1:0]   o_i,
    output logic [$clog2(MAX_MATRICES+1)-1:0]   o_k,
    output logic [$clog2(MAX_MATRICES+1)-1:0]   o_j,
    output logic [$clog2(MAX_MATRICES+1)-1:0]   o_dim_wa,
    output logic [$clog2(MAX_MATRICES+1)-1:0]   o_dim_ra,
    output logic [$clog2(MAX_MATRICES+1)-1:0]   o_dim_rb
);

    localparam int IW = $clog2(MAX_MATRICES + 1);
    localparam int CW = $clog2(MAX_MATRICES + 2);
    localparam logic [CW-1:0] FULL = CW'(MAX_MATRICES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_MUL1  = 3'd3;
    localparam logic [2:0] S_MUL2  = 3'd4;
    localparam logic [2:0] S_ACC   = 3'd5;
    localparam logic [2:0] S_WR    = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]                   r_state, n_state;
    logic [CW-1:0]                r_cnt, n_cnt;
    logic                         r_tm, n_tm;
    logic [IW-1:0]                r_n, n_n;
    logic [IW-1:0]                r_len, n_len;
    logic [IW-1:0]                r_i, n_i;
    logic [IW-1:0]                r_k, n_k;
    logic [mcm_pkg::STAT_W-1:0]   r_status, n_status;
    logic                         r_use_best, n_use_best;
    logic                         r_out_valid, n_out_valid;

    logic                         w_acc_in;
    logic                         w_full;
    logic [CW-1:0]                w_cnt1;
    logic [IW-1:0]                w_j;
    logic [IW-1:0]                w_k1;
    mcm_pkg::t_dp_cmd             w_cmd;

    assign w_acc_in = i_in_valid && (r_state == S_IDLE);
    assign w_full   = (r_cnt == FULL);
    assign w_cnt1   = w_full ? r_cnt : CW'(r_cnt + CW'(1));
    assign w_j      = IW'(r_i + r_len - IW'(1));
    assign w_k1     = IW'(r_k + IW'(1));

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_tm        = r_tm;
        n_n         = r_n;
        n_len       = r_len;
        n_i         = r_i;
        n_k         = r_k;
        n_status    = r_status;
        n_use_best  = r_use_best;
        n_out_valid = r_out_valid;
        w_cmd       = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_acc_in) begin
                    if (!w_full) begin
                        w_cmd.dim_wr = 1'b1;
                        n_cnt        = w_cnt1;
                    end else begin
                        n_tm = 1'b1;
                    end
                    if (i_in_last) begin
                        n_cnt      = '0;
                        n_tm       = 1'b0;
                        n_len      = IW'(2);
                        n_i        = '0;
                        n_n        = IW'(w_cnt1 - CW'(1));
                        n_use_best = 1'b0;
                        n_status   = mcm_pkg::ST_OK;
                        n_state    = S_OUT;
                        if (r_tm || w_full) begin
                            n_status = mcm_pkg::ST_LONG;
                        end else if (w_cnt1 < CW'(2)) begin
                            n_status = mcm_pkg::ST_SHORT;
                        end else if (w_cnt1 > CW'(2)) begin
                            // single matrix costs zero, otherwise run the table
                            n_state = S_SETUP;
                        end
                    end
                end
            end
            S_SETUP: begin
                n_k     = r_i;
                n_state = S_RD;
            end
            S_RD: begin
                w_cmd.rd         = 1'b1;
                w_cmd.first      = (r_k == r_i);
                w_cmd.last_split = (w_k1 == w_j);
                n_state          = S_MUL1;
            end
            S_MUL1: begin
                w_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                w_cmd.mul2 = 1'b1;
                n_state    = S_ACC;
            end
            S_ACC: begin
                w_cmd.acc   = 1'b1;
                w_cmd.first = (r_k == r_i);
                if (w_k1 == w_j) begin
                    n_state = S_WR;
                end else begin
                    n_k     = w_k1;
                    n_state = S_RD;
                end
            end
            S_WR: begin
                w_cmd.cost_wr = 1'b1;
                n_state       = S_SETUP;
                if (({1'b0, r_i} + {1'b0, r_len}) == {1'b0, r_n}) begin
                    if (r_len == r_n) begin
                        n_use_best = 1'b1;
                        n_state    = S_OUT;
                    end else begin
                        n_len = IW'(r_len + IW'(1));
                        n_i   = '0;
                    end
                end else begin
                    n_i = IW'(r_i + IW'(1));
                end
            end
            S_OUT: begin
                w_cmd.out_status   = r_status;
                w_cmd.out_use_best = r_use_best;
                if (!r_out_valid || !i_out_stall) begin
                    w_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_tm        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_tm        <= n_tm;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_len      <= n_len;
        r_i        <= n_i;
        r_k        <= n_k;
        r_status   <= n_status;
        r_use_best <= n_use_best;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;
    assign o_i         = r_i;
    assign o_k         = r_k;
    assign o_j         = w_j;
    assign o_dim_wa    = r_cnt[IW-1:0];
    assign o_dim_ra    = (r_state == S_SETUP) ? r_i : w_k1;
    assign o_dim_rb    = IW'(w_j + IW'(1));

endmodule

>>> sv/matrix_chain_min_cost_top.sv
// Matrix chain minimum cost: one dimension per beat, one cost result after the last beat.
// Loading: one dimension beat per cycle. After the last beat of a chain of n matrices the
// shared multiply/add unit runs read, two multiply steps and accumulate per split point,
// with setup and write-back per interval, then posts the result; input stalls meanwhile.
// Short, long and single-matrix chains skip the table and go straight to posting the result.
// Synchronous active-low reset clears control only; table memories need no clearing pass.
module matrix_chain_min_cost_top #(
    parameter int MAX_MATRICES = 32,
    parameter int DIM_BITS     = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  mcm_pkg::t_in_beat   i_in_beat,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output mcm_pkg::t_out_beat  o_out_beat,
    input  logic                i_out_stall
);

    localparam int IW = $clog2(MAX_MATRICES + 1);

    mcm_pkg::t_dp_cmd w_cmd;
    logic [IW-1:0]    w_i;
    logic [IW-1:0]    w_k;
    logic [IW-1:0]    w_j;
    logic [IW-1:0]    w_dim_wa;
    logic [IW-1:0]    w_dim_ra;
    logic [IW-1:0]    w_dim_rb;

    mcm_ctrl #(
        .MAX_MATRICES(MAX_MATRICES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_beat.last),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd),
        .o_i         (w_i),
        .o_k         (w_k),
        .o_j         (w_j),
        .o_dim_wa    (w_dim_wa),
        .o_dim_ra    (w_dim_ra),
        .o_dim_rb    (w_dim_rb)
    );

    mcm_dpath #(
        .MAX_MATRICES(MAX_MATRICES),
        .DIM_BITS    (DIM_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_in_dim   (i_in_beat.dim),
        .i_i        (w_i),
        .i_k        (w_k),
        .i_j        (w_j),
        .i_dim_wa   (w_dim_wa),
        .i_dim_ra   (w_dim_ra),
        .i_dim_rb   (w_dim_rb),
        .o_out_beat (o_out_beat)
    );

    // a closing beat always blocks the next beat until its result is posted
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_beat.last) |=> o_in_stall)
        else $error("input not stalled after closing beat");

    a_err_zero_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_beat.status == mcm_pkg::ST_OK || o_out_beat.min_cost == '0))
        else $error("error result carries nonzero cost");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result posted without a closing beat");

endmodule

>>> tb/matrix_chain_min_cost_top_tb.sv
// Self-checking testbench for the matrix chain minimum cost block.
`timescale 1ns / 1ps

module matrix_chain_min_cost_top_tb;

    localparam int MAX_M       = 32;
    localparam int MAX_DIMS    = MAX_M + 1;
    localparam int HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DIR_N       = 22;

    localparam logic [63:0] COST_TOP = 64'(mcm_pkg::COST_MAX);

    // Directed chains as {dim, last}: short chain, single matrix at full width,
    // full-width triple, textbook chains, zero dimensions, alternating extremes.
    localparam logic [mcm_pkg::DIM_W:0] DIRECTED [DIR_N] = '{
        {16'h0000, 1'b1},
        {16'hFFFF, 1'b0}, {16'hFFFF, 1'b1},
        {16'hFFFF, 1'b0}, {16'hFFFF, 1'b0}, {16'hFFFF, 1'b1},
        {16'd10, 1'b0}, {16'd30, 1'b0}, {16'd5, 1'b0}, {16'd60, 1'b1},
        {16'd0, 1'b0}, {16'd5, 1'b0}, {16'd7, 1'b0}, {16'd0, 1'b1},
        {16'd40, 1'b0}, {16'd20, 1'b0}, {16'd30, 1'b0}, {16'd10, 1'b0}, {16'd30, 1'b1},
        {16'd1, 1'b0}, {16'hFFFF, 1'b0}, {16'd1, 1'b1}
    };

    class chain_cost_tracker;
        logic [mcm_pkg::DIM_W-1:0] dims [MAX_DIMS];
        int unsigned               n_dims;
        bit                        overflowed;
        mcm_pkg::t_out_beat        pending_costs [$];
        int                        errors;

        function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
            logic [63:0] s;
            if (a >= COST_TOP || b >= COST_TOP) return COST_TOP;
            s = a + b;
            return (s > COST_TOP) ? COST_TOP : s;
        endfunction

        function logic [63:0] triple(logic [63:0] a, logic [63:0] b, logic [63:0] c);
            logic [63:0] ab;
            ab = a * b;
            if (ab == 0 || c == 0) return 64'd0;
            if (ab > COST_TOP / c) return COST_TOP;
            return ab * c;
        endfunction

        // Interval DP over n matrices; each interval seeds its minimum from the first split.
        function logic [63:0] chain_cost(int unsigned n);
            logic [63:0] cost [MAX_M][MAX_M];
            logic [63:0] best;
            logic [63:0] cand;
            int          j;
            for (int i = 0; i < n; i++) cost[i][i] = 64'd0;
            for (int span = 2; span <= n; span++) begin
                for (int i = 0; i + span <= n; i++) begin
                    j = i + span - 1;
                    best = COST_TOP;
                    for (int k = i; k < j; k++) begin
                        cand = sat_add(sat_add(cost[i][k], cost[k+1][j]),
                                       triple(dims[i], dims[k+1], dims[j+1]));
                        if (k == i || cand < best) best = cand;
                    end
                    cost[i][j] = best;
                end
            end
            return cost[0][n-1];
        endfunction

        function void note_beat(mcm_pkg::t_in_beat b);
            mcm_pkg::t_out_beat want;
            logic [63:0]        total;
            if (n_dims < MAX_DIMS) begin
                dims[n_dims] = b.dim;
                n_dims++;
            end else begin
                overflowed = 1'b1;
            end
            if (b.last) begin
                want.min_cost = '0;
                if (overflowed) begin
                    want.status = mcm_pkg::ST_LONG;
                end else if (n_dims < 2) begin
                    want.status = mcm_pkg::ST_SHORT;
                end else begin
                    want.status = mcm_pkg::ST_OK;
                    total = chain_cost(n_dims - 1);
                    want.min_cost = total[mcm_pkg::COST_W-1:0];
                end
                pending_costs.push_back(want);
                n_dims = 0;
                overflowed = 1'b0;
            end
        endfunction

        function void check_result(mcm_pkg::t_out_beat got);
            mcm_pkg::t_out_beat want;
            if (pending_costs.size() == 0) begin
                $error("unexpected result beat: min_cost %0d status %0d",
                       got.min_cost, got.status);
                errors++;
                return;
            end
            want = pending_costs.pop_front();
            if (got.min_cost !== want.min_cost) begin
                $error("min_cost mismatch: expected %0d, actual %0d",
                       want.min_cost, got.min_cost);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
        endfunction

        function int pending();
            return pending_costs.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    mcm_pkg::t_in_beat  i_in_beat;
    logic               o_in_stall;
    logic               o_out_valid;
    mcm_pkg::t_out_beat o_out_beat;
    logic               i_out_stall;

    chain_cost_tracker tracker = new();
    int items_sent  = 0;
    int cycle_count = 0;
    bit tx_gaps     = 1'b0;
    bit rx_gaps     = 1'b0;
    bit hold_req    = 1'b0;

    matrix_chain_min_cost_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_beat   (i_in_beat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat),
        .i_out_stall (i_out_stall)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            tracker.check_result(o_out_beat);
        end
    end

    // Result side: random stall bursts, quiet stretches, and one long hold on request.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (rx_gaps) begin
                case ($urandom_range(0, 11))
                    0, 1:    begin
                        i_out_stall <= 1'b1;
                        repeat ($urandom_range(1, 18)) @(posedge i_clk);
                        i_out_stall <= 1'b0;
                    end
                    2:       repeat ($urandom_range(20, 80)) @(posedge i_clk);
                    default: ;
                endcase
            end
        end
    end

    task automatic send_beat(input mcm_pkg::t_in_beat b);
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        tracker.note_beat(b);
        items_sent++;
    endtask

    task automatic tx_pause();
        if (tx_gaps) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 18)) @(posedge i_clk);
                end
                default: ;
            endcase
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [mcm_pkg::DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return mcm_pkg::DIM_W'($urandom_range(1, 64));
            default: return mcm_pkg::DIM_W'($urandom());
        endcase
    endfunction

    // Mostly short chains; rare full-size and oversize chains keep the compute time bounded.
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return MAX_DIMS;
        if (r < 5) return $urandom_range(MAX_DIMS + 1, MAX_DIMS + 7);
        if (r < 12) return $urandom_range(10, 20);
        return $urandom_range(1, 9);
    endfunction

    task automatic send_chain(input int len, input bit all_max);
        mcm_pkg::t_in_beat b;
        for (int i = 0; i < len; i++) begin
            tx_pause();
            b.dim  = all_max ? '1 : pick_dim();
            b.last = (i == len - 1);
            send_beat(b);
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_beat  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_N; i++) send_beat(mcm_pkg::t_in_beat'(DIRECTED[i]));
        wait_drained();

        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        send_chain(MAX_DIMS, 1'b1);
        send_chain(MAX_DIMS, 1'b0);
        send_chain(MAX_DIMS + 4, 1'b0);
        while (items_sent < 450) send_chain(pick_len(), 1'b0);

        // long receiver hold while chains keep coming, so the block backs up
        hold_req = 1'b1;
        repeat (12) send_chain($urandom_range(1, 4), 1'b0);
        while (items_sent < 650) send_chain(pick_len(), 1'b0);
        wait_drained();

        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        while (items_sent < 770) send_chain(pick_len(), 1'b0);
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
